// ===== hw/rtl/ggxhs_pkg.sv =====
// shared types and constants for the ggx hemisphere sampler
// holds the beat structs, default parameters, cordic gain and angle table
// no dependencies
package ggxhs_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FRAC_BITS_DEF     = 16;
    localparam int ANG_TABLE_LEN     = 24;

    // inverse of the limiting cordic gain, q0.30
    localparam logic [29:0] KINV_Q30 = 30'd652032874;

    typedef struct packed {
        logic [15:0] azimuth_random;
        logic [15:0] elevation_random;
        logic [15:0] roughness;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic [14:0]        dir_y;
        logic signed [15:0] dir_z;
    } dir_t;

    // arctangent of 2^-i in units of 2^-32 turn, truncated
    function automatic logic [31:0] cordic_angle(input int idx);
        case (idx)
            0:  return 32'h20000000;
            1:  return 32'h12E4051D;
            2:  return 32'h09FB385B;
            3:  return 32'h051111D4;
            4:  return 32'h028B0D43;
            5:  return 32'h0145D7E1;
            6:  return 32'h00A2F61E;
            7:  return 32'h00517C55;
            8:  return 32'h0028BE53;
            9:  return 32'h00145F2E;
            10: return 32'h000A2F98;
            11: return 32'h000517CC;
            12: return 32'h00028BE6;
            13: return 32'h000145F3;
            14: return 32'h0000A2F9;
            15: return 32'h0000517C;
            16: return 32'h000028BE;
            17: return 32'h0000145F;
            18: return 32'h00000A2F;
            19: return 32'h00000517;
            20: return 32'h0000028B;
            21: return 32'h00000145;
            22: return 32'h000000A2;
            23: return 32'h00000051;
            default: return 32'h00000000;
        endcase
    endfunction

endpackage

// ===== hw/rtl/ggxhs_div_cell.sv =====
// one restoring divider cell: settles one quotient bit per clock
// depends on ggxhs_pkg
module ggxhs_div_cell
    import ggxhs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = 0
)
(
    input  logic                   clk,
    input  logic [2*FRAC_BITS:0]   rem_in,
    input  logic [FRAC_BITS:0]     den_in,
    input  logic [FRAC_BITS:0]     q_in,
    output logic [2*FRAC_BITS:0]   rem_out,
    output logic [FRAC_BITS:0]     den_out,
    output logic [FRAC_BITS:0]     q_out
);

    localparam int DW = 2 * FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;

    logic [DW-1:0] dsh;
    logic          ge;
    logic [DW-1:0] rem_next, rem_reg;
    logic [QW-1:0] q_next, q_reg, den_reg;

    // trial subtract of the shifted divisor
    always_comb
    begin
        dsh      = DW'(den_in) << BIT;
        ge       = (rem_in >= dsh);
        rem_next = ge ? (rem_in - dsh) : rem_in;
        q_next   = q_in | (QW'(ge) << BIT);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_in;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;
    assign den_out = den_reg;

endmodule

// ===== hw/rtl/ggxhs_sqrt_cell.sv =====
// one digit-by-digit square root cell: settles one root bit per clock
// depends on ggxhs_pkg
module ggxhs_sqrt_cell
    import ggxhs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = 0
)
(
    input  logic                   clk,
    input  logic [2*FRAC_BITS:0]   rem_in,
    input  logic [FRAC_BITS:0]     q_in,
    output logic [2*FRAC_BITS:0]   rem_out,
    output logic [FRAC_BITS:0]     q_out
);

    localparam int DW = 2 * FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 1;

    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next, rem_reg;
    logic [QW-1:0] q_next, q_reg;

    // (q + 2^b)^2 - q^2 = q*2^(b+1) + 2^(2b)
    always_comb
    begin
        trial    = ((DW + 1)'(q_in) << (BIT + 1)) + ((DW + 1)'(1) << (2 * BIT));
        ge       = ({1'b0, rem_in} >= trial);
        rem_next = ge ? DW'({1'b0, rem_in} - trial) : rem_in;
        q_next   = q_in | (QW'(ge) << BIT);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign rem_out = rem_reg;
    assign q_out   = q_reg;

endmodule

// ===== hw/rtl/ggxhs_cordic_cell.sv =====
// one rotation-mode cordic cell: one micro-rotation per clock
// depends on ggxhs_pkg (angle table)
module ggxhs_cordic_cell
    import ggxhs_pkg::*;
#(
    parameter int XW  = FRAC_BITS_DEF + 3,
    parameter int IDX = 0
)
(
    input  logic                 clk,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [33:0]   z_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [33:0]   z_out
);

    localparam logic signed [33:0] ANG = $signed({2'b00, cordic_angle(IDX)});

    logic signed [XW-1:0] dx, dy, x_next, y_next, x_reg, y_reg;
    logic signed [33:0]   z_next, z_reg;

    // rotate toward zero residual angle
    always_comb
    begin
        dx = y_in >>> IDX;
        dy = x_in >>> IDX;
        if (!z_in[33])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - ANG;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + ANG;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ===== hw/rtl/ggx_hemisphere_sampler.sv =====
// ggx importance sampled hemisphere direction, fully pipelined
// depends on ggxhs_pkg, ggxhs_div_cell, ggxhs_sqrt_cell, ggxhs_cordic_cell
//
// usage:
//   request beat: azimuth_random, elevation_random, roughness (q0.16) is taken
//   at a rising edge with start high and busy low. busy stays low, so a new
//   beat may enter every cycle: one sample per cycle sustained.
//   result beat: dir_x, dir_y, dir_z on result, marked by done for exactly one
//   cycle. the receiver cannot stall; every result must be taken when shown.
// pipeline: the beat passes 4 front stages, FRAC_BITS+1 divider cells, clamp,
//   FRAC_BITS+1 root cells, cordic entry, CORDIC_STAGES cordic cells and the
//   output register, 57 registers by default, the first loaded at the
//   accepting edge; done rises together with the output register.
//   the divider and root chains make up most of those registers.
// reset: rst_n clears the valid line; beats in flight are dropped, no
//   clearing pass is needed.
module ggx_hemisphere_sampler
    import ggxhs_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  sample_t request,
    output logic    done,
    output dir_t    result
);

    localparam int F   = FRAC_BITS;
    localparam int QW  = F + 1;
    localparam int DW  = 2 * F + 1;
    localparam int XW  = F + 3;
    localparam int NS  = (CORDIC_STAGES > ANG_TABLE_LEN) ? ANG_TABLE_LEN :
                         (CORDIC_STAGES < 1) ? 1 : CORDIC_STAGES;
    localparam int LAT_MID = 2 * F + 3;
    localparam int TOT     = 2 * F + 9 + NS;
    localparam int SH_IN_UP  = (F >= 16) ? F - 16 : 0;
    localparam int SH_IN_DN  = (F >= 16) ? 0 : 16 - F;
    localparam int SH_OUT_UP = (F >= 15) ? 0 : 15 - F;
    localparam int SH_OUT_DN = (F >= 15) ? F - 15 : 0;
    localparam logic [QW-1:0] ONE = QW'(1) << F;
    localparam logic signed [33:0] QTR  = 34'sd1073741824;
    localparam logic signed [33:0] HALF = 34'sd2147483648;

    typedef struct packed {
        logic        neg;
        logic [14:0] ycos;
    } side_t;

    function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            return 16'sh7FFF;
        else if (v < -48'sd32768)
            return -16'sh8000;
        else
            return v[15:0];
    endfunction

    logic           accept;
    logic [TOT-1:0] valid_reg;

    logic [15:0]   u_s0_reg, u_s1_reg, u_s2_reg, u_s3_reg;
    logic [F-1:0]  e_s0_reg, e_s1_reg, e_s2_reg;
    logic [F-1:0]  r_s0_reg, a_s1_reg, a2_s2_reg;
    logic [QW-1:0] num_s3_reg, den_s3_reg;
    logic [2*F-1:0] rr, aa;
    logic [QW-1:0]  oma, pf;
    logic [DW-1:0]  prod;

    logic [DW-1:0] div_rem [F+2];
    logic [QW-1:0] div_den [F+2];
    logic [QW-1:0] div_q   [F+2];

    logic [QW-1:0] cos2_next, cos2_reg, sin2_reg;
    logic [DW-1:0] sqc_rem [F+2];
    logic [QW-1:0] sqc_q   [F+2];
    logic [DW-1:0] sqs_rem [F+2];
    logic [QW-1:0] sqs_q   [F+2];

    logic [15:0] u_dly_reg [LAT_MID];

    logic [F+30:0]        prodk;
    logic signed [33:0]   z_raw, z_red;
    logic                 neg_c0;
    logic [39:0]          yc40;
    logic signed [XW-1:0] x0_reg;
    logic signed [33:0]   z0_reg;
    side_t                side_c0_reg;
    side_t                side_reg [NS];

    logic signed [XW-1:0] cx [NS+1];
    logic signed [XW-1:0] cy [NS+1];
    logic signed [33:0]   cz [NS+1];

    logic signed [XW-1:0] xf, yf;
    dir_t                 result_next, result_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // valid line, one bit per pipeline stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[TOT-2:0], accept};
    end

    // front stages: rescale, square roughness twice, divider operands
    assign rr   = r_s0_reg * r_s0_reg;
    assign aa   = a_s1_reg * a_s1_reg;
    assign oma  = ONE - {1'b0, a2_s2_reg};
    assign prod = DW'(oma) * DW'(e_s2_reg);
    assign pf   = prod[2*F:F];

    always_ff @(posedge clk)
    begin
        u_s0_reg   <= request.azimuth_random;
        e_s0_reg   <= F'((40'(request.elevation_random) << SH_IN_UP) >> SH_IN_DN);
        r_s0_reg   <= F'((40'(request.roughness) << SH_IN_UP) >> SH_IN_DN);
        u_s1_reg   <= u_s0_reg;
        e_s1_reg   <= e_s0_reg;
        a_s1_reg   <= rr[2*F-1:F];
        u_s2_reg   <= u_s1_reg;
        e_s2_reg   <= e_s1_reg;
        a2_s2_reg  <= aa[2*F-1:F];
        u_s3_reg   <= u_s2_reg;
        num_s3_reg <= ONE - {1'b0, e_s2_reg};
        den_s3_reg <= ONE - pf;
    end

    // divider chain for cos^2 = num / den
    assign div_rem[0] = DW'(num_s3_reg) << F;
    assign div_den[0] = den_s3_reg;
    assign div_q[0]   = '0;

    for (genvar j = 0; j <= F; j++)
    begin : g_div
        ggxhs_div_cell #(.FRAC_BITS(F), .BIT(F - j)) u_cell (
            .clk     (clk),
            .rem_in  (div_rem[j]),
            .den_in  (div_den[j]),
            .q_in    (div_q[j]),
            .rem_out (div_rem[j+1]),
            .den_out (div_den[j+1]),
            .q_out   (div_q[j+1])
        );
    end

    // clamp and complement
    assign cos2_next = (div_q[F+1] > ONE) ? ONE : div_q[F+1];

    always_ff @(posedge clk)
    begin
        cos2_reg <= cos2_next;
        sin2_reg <= ONE - cos2_next;
    end

    // root chains for cos and sin theta
    assign sqc_rem[0] = DW'(cos2_reg) << F;
    assign sqc_q[0]   = '0;
    assign sqs_rem[0] = DW'(sin2_reg) << F;
    assign sqs_q[0]   = '0;

    for (genvar j = 0; j <= F; j++)
    begin : g_sqrt
        ggxhs_sqrt_cell #(.FRAC_BITS(F), .BIT(F - j)) u_cos (
            .clk     (clk),
            .rem_in  (sqc_rem[j]),
            .q_in    (sqc_q[j]),
            .rem_out (sqc_rem[j+1]),
            .q_out   (sqc_q[j+1])
        );
        ggxhs_sqrt_cell #(.FRAC_BITS(F), .BIT(F - j)) u_sin (
            .clk     (clk),
            .rem_in  (sqs_rem[j]),
            .q_in    (sqs_q[j]),
            .rem_out (sqs_rem[j+1]),
            .q_out   (sqs_q[j+1])
        );
    end

    // azimuth rides alongside the divider and root chains
    always_ff @(posedge clk)
    begin
        u_dly_reg[0] <= u_s3_reg;
        for (int k = 1; k < LAT_MID; k++)
            u_dly_reg[k] <= u_dly_reg[k-1];
    end

    // cordic entry: gain-corrected start vector and quarter-turn reduction
    always_comb
    begin
        prodk  = (F + 31)'(sqs_q[F+1]) * (F + 31)'(KINV_Q30);
        z_raw  = 34'($signed({u_dly_reg[LAT_MID-1], 16'h0000}));
        neg_c0 = 1'b0;
        z_red  = z_raw;
        if (z_raw > QTR)
        begin
            z_red  = z_raw - HALF;
            neg_c0 = 1'b1;
        end
        else if (z_raw < -QTR)
        begin
            z_red  = z_raw + HALF;
            neg_c0 = 1'b1;
        end
        yc40 = (40'(sqc_q[F+1]) << SH_OUT_UP) >> SH_OUT_DN;
    end

    always_ff @(posedge clk)
    begin
        x0_reg           <= $signed(XW'(prodk[F+30:30]));
        z0_reg           <= z_red;
        side_c0_reg.neg  <= neg_c0;
        side_c0_reg.ycos <= (yc40 > 40'd32767) ? 15'h7FFF : yc40[14:0];
    end

    // cordic chain
    assign cx[0] = x0_reg;
    assign cy[0] = '0;
    assign cz[0] = z0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        ggxhs_cordic_cell #(.XW(XW), .IDX(i)) u_cell (
            .clk   (clk),
            .x_in  (cx[i]),
            .y_in  (cy[i]),
            .z_in  (cz[i]),
            .x_out (cx[i+1]),
            .y_out (cy[i+1]),
            .z_out (cz[i+1])
        );
    end

    // sign flag and cos theta ride alongside the cordic chain
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_c0_reg;
        for (int k = 1; k < NS; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // output stage: undo back-half reduction, convert to q1.15, saturate
    always_comb
    begin
        xf = side_reg[NS-1].neg ? -cx[NS] : cx[NS];
        yf = side_reg[NS-1].neg ? -cy[NS] : cy[NS];
        result_next.dir_x = sat16((48'(xf) <<< SH_OUT_UP) >>> SH_OUT_DN);
        result_next.dir_z = sat16((48'(yf) <<< SH_OUT_UP) >>> SH_OUT_DN);
        result_next.dir_y = side_reg[NS-1].ycos;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = valid_reg[TOT-1];
    assign result = result_reg;

`ifndef SYNTHESIS
    // every result beat traces back to an accepted request
    a_done_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(valid_reg[0], TOT - 1))
        else $error("done without matching request");

    // divider quotient never exceeds one since den >= num
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[F+4] |-> (div_q[F+1] <= ONE))
        else $error("cos^2 quotient above one");

    // accept and done spacing holds for back to back beats
    a_done_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(done)) |-> $past(valid_reg[0] && valid_reg[1], TOT - 1))
        else $error("result beat order broken");
`endif

endmodule

// ===== tb/ggx_hemisphere_sampler_test.sv =====
// testbench for the ggx hemisphere sampler: directed and random request beats
// checked field by field against an in-bench fixed-point predictor
// depends on ggxhs_pkg and ggx_hemisphere_sampler
`timescale 1ns / 1ps

module ggx_hemisphere_sampler_test;
    import ggxhs_pkg::*;

    localparam int STAGES   = CORDIC_STAGES_DEF;
    localparam int FBITS    = FRAC_BITS_DEF;
    localparam int LATENCY  = 2 * FBITS + STAGES + 9;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1930;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t request;
    logic    done;
    dir_t    result;

    sample_t pending_q[$];
    dir_t    expected_dirs[$];
    int      fail_count;
    int      idle_cycles;
    bit      hold_until_drained;
    int      burst_left;
    int      gap_left;

    ggx_hemisphere_sampler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    // floor shift of a signed value
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint sat16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // ggx direction for one request beat (frac bits fixed at 16)
    function automatic dir_t ggx_direction(input sample_t s);
        longint unsigned one, e, r, a, a2, num, den, cos2, sin2, cosv, sinv;
        longint x, y, z, xn, yn;
        bit     flip;
        dir_t   d;
        one  = 64'd1 << FBITS;
        e    = s.elevation_random;
        r    = s.roughness;
        a    = (r * r) >> FBITS;
        a2   = (a * a) >> FBITS;
        if (a2 > one)
            a2 = one;
        num  = one - e;
        den  = one - (((one - a2) * e) >> FBITS);
        if (den == 0)
            den = 1;
        cos2 = (num << FBITS) / den;
        if (cos2 > one)
            cos2 = one;
        sin2 = one - cos2;
        cosv = int_sqrt(cos2 << FBITS);
        sinv = int_sqrt(sin2 << FBITS);
        // azimuth folded into the front half circle
        flip = 0;
        z = longint'({s.azimuth_random, 16'h0000});
        if (z >= (64'sd1 <<< 31))
            z -= (64'sd1 <<< 32);
        if (z > (64'sd1 <<< 30))
        begin
            z -= (64'sd1 <<< 31);
            flip = 1;
        end
        else if (z < -(64'sd1 <<< 30))
        begin
            z += (64'sd1 <<< 31);
            flip = 1;
        end
        x = longint'((sinv * longint'(KINV_Q30)) >> 30);
        y = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                xn = x - shr_floor(y, i);
                yn = y + shr_floor(x, i);
                z -= longint'(cordic_angle(i));
            end
            else
            begin
                xn = x + shr_floor(y, i);
                yn = y - shr_floor(x, i);
                z += longint'(cordic_angle(i));
            end
            x = xn;
            y = yn;
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        d.dir_x = 16'(sat16(shr_floor(x, FBITS - 15)));
        d.dir_z = 16'(sat16(shr_floor(y, FBITS - 15)));
        cosv = cosv >> (FBITS - 15);
        d.dir_y = (cosv > 32767) ? 15'h7FFF : 15'(cosv);
        return d;
    endfunction

    function automatic sample_t make_sample(input int u, input int e, input int r);
        sample_t s;
        s.azimuth_random   = 16'(u);
        s.elevation_random = 16'(e);
        s.roughness        = 16'(r);
        return s;
    endfunction

    // append one request beat to the pending list
    task automatic add_pending(input sample_t s);
        pending_q.insert(pending_q.size(), s);
    endtask

    // clock and reset
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    // stimulus: directed corners then mostly random beats
    initial
    begin
        int u;
        int e;
        int r;
        fail_count = 0;
        hold_until_drained = 0;
        add_pending(make_sample(0, 0, 0));
        add_pending(make_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_pending(make_sample(16'h1234, 16'h8000, 0));
        add_pending(make_sample(0, 16'hFFFF, 16'hFFFF));
        add_pending(make_sample(16'h4000, 16'h8000, 16'hFFFF));
        add_pending(make_sample(16'h4001, 16'h8000, 16'hFFFF));
        add_pending(make_sample(16'h8000, 16'h8000, 16'h8000));
        add_pending(make_sample(16'hC000, 16'hC000, 16'h8000));
        add_pending(make_sample(16'hBFFF, 16'h4000, 16'h4000));
        add_pending(make_sample(16'hC001, 16'h0001, 16'hFFFF));
        add_pending(make_sample(16'h2000, 16'hFFFF, 16'h0001));
        add_pending(make_sample(16'h6000, 16'h0000, 16'hFFFF));
        add_pending(make_sample(16'hE000, 16'h7FFF, 16'h0100));
        add_pending(make_sample(16'hA000, 16'hFFFE, 16'hC000));
        add_pending(make_sample(16'h3FFF, 16'h5555, 16'hAAAA));
        add_pending(make_sample(16'h7FFF, 16'hAAAA, 16'h5555));
        add_pending(make_sample(16'h8001, 16'h0100, 16'h00FF));
        add_pending(make_sample(16'hFFFF, 16'h0000, 16'h0000));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            u = $urandom_range(0, 65535);
            e = $urandom_range(0, 65535);
            case ($urandom_range(0, 3))
                0: r = $urandom_range(0, 255);
                1: r = $urandom_range(65280, 65535);
                default: r = $urandom_range(0, 65535);
            endcase
            if ($urandom_range(0, 15) == 0)
                e = $urandom_range(0, 1) ? 0 : 65535;
            add_pending(make_sample(u, e, r));
            if (n == N_RANDOM / 2)
                add_pending(make_sample(16'h4000, 16'h4000, 16'h4000));
        end
    end

    // driver: bursts and gaps, one mid-run pause until the pipe drains
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start      <= 0;
            request    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (pending_q.size() == N_RANDOM / 2 && !hold_until_drained)
                hold_until_drained = 1;
            if (hold_until_drained == 1 && expected_dirs.size() != 0)
                start <= 0;
            else if (gap_left > 0)
            begin
                start    <= 0;
                gap_left <= gap_left - 1;
            end
            else if (pending_q.size() != 0)
            begin
                if (hold_until_drained == 1)
                    hold_until_drained = 0;
                start   <= 1;
                request <= pending_q[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 0;
        end
    end

    // monitor: record accepted beats and check results
    always @(posedge clk)
    begin
        dir_t want;
        if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (start && !busy)
            begin
                expected_dirs.insert(expected_dirs.size(), ggx_direction(request));
                void'(pending_q.pop_front());
                idle_cycles <= 0;
            end
            if (done)
            begin
                idle_cycles <= 0;
                if (expected_dirs.size() == 0)
                begin
                    $error("result beat with no request pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_dirs.pop_front();
                    if (result.dir_x !== want.dir_x)
                    begin
                        $error("dir_x expected %0d got %0d", want.dir_x, result.dir_x);
                        fail_count++;
                    end
                    if (result.dir_y !== want.dir_y)
                    begin
                        $error("dir_y expected %0d got %0d", want.dir_y, result.dir_y);
                        fail_count++;
                    end
                    if (result.dir_z !== want.dir_z)
                    begin
                        $error("dir_z expected %0d got %0d", want.dir_z, result.dir_z);
                        fail_count++;
                    end
                end
            end
        end
        else
            idle_cycles <= 0;
    end

    // end of run and watchdog
    initial
    begin
        start   = 0;
        request = '0;
        idle_cycles = 0;
        @(posedge rst_n);
        repeat (10) @(posedge clk);
        while ((pending_q.size() != 0 || expected_dirs.size() != 0)
               && idle_cycles < WATCHDOG)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG)
            $display("Mismatches found");
        else
        begin
            repeat (LATENCY + 10) @(posedge clk);
            if (fail_count == 0 && expected_dirs.size() == 0)
                $display("No mismatches found");
            else
                $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/ggxhs_pkg.sv
hw/rtl/ggxhs_div_cell.sv
hw/rtl/ggxhs_sqrt_cell.sv
hw/rtl/ggxhs_cordic_cell.sv
hw/rtl/ggx_hemisphere_sampler.sv
tb/ggx_hemisphere_sampler_test.sv
